// File: rtl/tga_pkg.sv
`timescale 1ns / 1ps

package tga_pkg;

  localparam int unsigned OutDataW = 88;
  localparam int unsigned FifoDepth = 2;

  // Result status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_MAP_TYPE     = 4'd1;
  localparam logic [3:0] ST_IMAGE_TYPE   = 4'd2;
  localparam logic [3:0] ST_MISSING_MAP  = 4'd3;
  localparam logic [3:0] ST_UNNEEDED_MAP = 4'd4;
  localparam logic [3:0] ST_FIRST_NO_MAP = 4'd5;
  localparam logic [3:0] ST_FIRST_RANGE  = 4'd6;
  localparam logic [3:0] ST_MAP_LENGTH   = 4'd7;
  localparam logic [3:0] ST_ENTRY_NO_MAP = 4'd8;
  localparam logic [3:0] ST_ENTRY_SIZE   = 4'd9;
  localparam logic [3:0] ST_DESC_RSVD    = 4'd10;
  localparam logic [3:0] ST_DEPTH        = 4'd11;
  localparam logic [3:0] ST_ID_SHORT     = 4'd12;
  localparam logic [3:0] ST_MAP_SHORT    = 4'd13;
  localparam logic [3:0] ST_DATA_SHORT   = 4'd14;

  localparam logic [7:0] DESC_RESERVED = 8'hC0;
  localparam logic [7:0] HEADER_LEN    = 8'd18;

  // Header summary handed from parser to checker
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  id_length;
    logic [3:0]  type_code;
    logic [15:0] first_entry;
    logic [15:0] entry_count;
    logic [2:0]  entry_bytes;
    logic [15:0] width;
    logic [15:0] height;
    logic [5:0]  pixel_bytes;
    logic        flip_x;
    logic        flip_y;
  } tga_job_t;

  function automatic logic size_ok(input logic [7:0] bits);
    return (bits == 8'd15) || (bits == 8'd16) || (bits == 8'd24) || (bits == 8'd32);
  endfunction

endpackage

// File: rtl/tga_fifo.sv
`timescale 1ns / 1ps

module tga_fifo
  import tga_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tga_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output tga_job_t pop_job
);

  tga_job_t   mem_r [FifoDepth];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'(FifoDepth));
  assign empty   = (count_r == 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/tga_front.sv
`timescale 1ns / 1ps

module tga_front
  import tga_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_valid,
  input  logic [7:0] byte_data,
  input  logic     byte_first,
  output logic     byte_ready,
  output logic     job_push,
  output tga_job_t job,
  input  logic     job_full
);

  localparam logic [4:0] POS_ID     = 5'd0;
  localparam logic [4:0] POS_MAPT   = 5'd1;
  localparam logic [4:0] POS_IMGT   = 5'd2;
  localparam logic [4:0] POS_FE_LO  = 5'd3;
  localparam logic [4:0] POS_FE_HI  = 5'd4;
  localparam logic [4:0] POS_EC_LO  = 5'd5;
  localparam logic [4:0] POS_EC_HI  = 5'd6;
  localparam logic [4:0] POS_EBITS  = 5'd7;
  localparam logic [4:0] POS_W_LO   = 5'd12;
  localparam logic [4:0] POS_W_HI   = 5'd13;
  localparam logic [4:0] POS_H_LO   = 5'd14;
  localparam logic [4:0] POS_H_HI   = 5'd15;
  localparam logic [4:0] POS_DEPTH  = 5'd16;
  localparam logic [4:0] POS_DESC   = 5'd17;

  logic [4:0]  pos_r;
  logic        stopped_r;
  logic [7:0]  id_r;
  logic        has_map_r;
  logic [3:0]  type_r;
  logic [15:0] fe_r;
  logic [15:0] ec_r;
  logic [2:0]  meb_r;
  logic [15:0] w_r;
  logic [15:0] h_r;
  logic [5:0]  pb_r;

  logic        accept, active, mapped, type_ok;
  logic [4:0]  pos;
  logic [3:0]  err;
  logic [15:0] fe_full, ec_full;
  logic [7:0]  depth;
  logic [8:0]  depth_sum;

  assign byte_ready = !job_full;
  assign accept     = byte_valid && byte_ready;
  assign active     = accept && (byte_first || !stopped_r);
  assign pos        = byte_first ? POS_ID : pos_r;
  assign fe_full    = {byte_data, fe_r[7:0]};
  assign ec_full    = {byte_data, ec_r[7:0]};
  assign type_ok    = (byte_data == 8'd1) || (byte_data == 8'd2) || (byte_data == 8'd3) ||
                      (byte_data == 8'd9) || (byte_data == 8'd10) || (byte_data == 8'd11);
  assign mapped     = (byte_data == 8'd1) || (byte_data == 8'd9);
  assign depth      = (byte_data == 8'd15) ? 8'd16 : byte_data;
  assign depth_sum  = {1'b0, depth} + 9'd7;

  always_comb begin
    err = ST_OK;
    case (pos)
      POS_MAPT: begin
        if (byte_data > 8'd1) err = ST_MAP_TYPE;
      end
      POS_IMGT: begin
        if (!type_ok) err = ST_IMAGE_TYPE;
        else if (!has_map_r && mapped) err = ST_MISSING_MAP;
        else if (has_map_r && !mapped) err = ST_UNNEEDED_MAP;
      end
      POS_FE_HI: begin
        if (fe_full != 16'd0 && !has_map_r) err = ST_FIRST_NO_MAP;
      end
      POS_EC_HI: begin
        if (!has_map_r && ec_full != 16'd0) err = ST_MAP_LENGTH;
        else if (has_map_r && ec_full == 16'd0) err = ST_MAP_LENGTH;
        else if (fe_r > ec_full) err = ST_FIRST_RANGE;
      end
      POS_EBITS: begin
        if (!has_map_r && byte_data != 8'd0) err = ST_ENTRY_NO_MAP;
        else if (has_map_r && !size_ok(byte_data)) err = ST_ENTRY_SIZE;
      end
      POS_DEPTH: begin
        if (!(size_ok(byte_data) || has_map_r)) err = ST_DEPTH;
      end
      POS_DESC: begin
        if ((byte_data & DESC_RESERVED) != 8'd0) err = ST_DESC_RSVD;
      end
      default: err = ST_OK;
    endcase
  end

  assign job_push = active && ((err != ST_OK) || (pos == POS_DESC));

  always_comb begin
    job.status      = err;
    job.id_length   = id_r;
    job.type_code   = type_r;
    job.first_entry = fe_r;
    job.entry_count = ec_r;
    job.entry_bytes = meb_r;
    job.width       = w_r;
    job.height      = h_r;
    job.pixel_bytes = pb_r;
    job.flip_x      = byte_data[4];
    job.flip_y      = byte_data[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_ID;
      stopped_r <= 1'b0;
    end else if (active) begin
      pos_r     <= pos + 5'd1;
      stopped_r <= job_push;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      case (pos)
        POS_ID:    id_r      <= byte_data;
        POS_MAPT:  has_map_r <= (byte_data == 8'd1);
        POS_IMGT:  type_r    <= byte_data[3:0];
        POS_FE_LO: fe_r      <= {8'd0, byte_data};
        POS_FE_HI: fe_r      <= fe_full;
        POS_EC_LO: ec_r      <= {8'd0, byte_data};
        POS_EC_HI: ec_r      <= ec_full;
        POS_EBITS: meb_r     <= (byte_data == 8'd15) ? 3'd2 : byte_data[5:3];
        POS_W_LO:  w_r       <= {8'd0, byte_data};
        POS_W_HI:  w_r       <= {byte_data, w_r[7:0]};
        POS_H_LO:  h_r       <= {8'd0, byte_data};
        POS_H_HI:  h_r       <= {byte_data, h_r[7:0]};
        POS_DEPTH: pb_r      <= depth_sum[8:3];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tga_back.sv
`timescale 1ns / 1ps

module tga_back
  import tga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         file_length,
  input  logic                job_empty,
  input  tga_job_t            job_in,
  output logic                job_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [OutDataW-1:0] res_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PIX  = 5'b00100,
    S_SUM  = 5'b01000,
    S_CHK  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  tga_job_t            job_r;
  logic [31:0]         wh_r;
  logic [8:0]          need1_r;
  logic [18:0]         need2_r;
  logic [37:0]         pix_r;
  logic [38:0]         need3_r;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                emit;
  logic [3:0]          status;
  logic [1:0]          img_class;
  logic [18:0]         map_size;

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign emit      = (state_r == S_CHK) && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;
  assign map_size  = 19'(job_r.entry_count) * 19'(job_r.entry_bytes);
  assign img_class = job_r.type_code[1:0] - 2'd1;

  always_comb begin
    if (job_r.status != ST_OK) status = job_r.status;
    else if ({23'd0, need1_r} > file_length) status = ST_ID_SHORT;
    else if ({13'd0, need2_r} > file_length) status = ST_MAP_SHORT;
    else if (job_r.type_code <= 4'd3 && need3_r > {7'd0, file_length}) status = ST_DATA_SHORT;
    else status = ST_OK;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!job_empty) state_nxt = (job_in.status != ST_OK) ? S_CHK : S_MUL;
      S_MUL:  state_nxt = S_PIX;
      S_PIX:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_CHK;
      S_CHK:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job_in;
    if (state_r == S_MUL) begin
      wh_r    <= job_r.width * job_r.height;
      need1_r <= {1'b0, HEADER_LEN} + {1'b0, job_r.id_length};
      need2_r <= 19'({1'b0, HEADER_LEN} + {1'b0, job_r.id_length}) + map_size;
    end
    if (state_r == S_PIX) pix_r <= wh_r * job_r.pixel_bytes;
    if (state_r == S_SUM) need3_r <= {20'd0, need2_r} + {1'b0, pix_r};
    if (emit) begin
      if (status != ST_OK) begin
        out_data_r <= {{(OutDataW-4){1'b0}}, status};
      end else begin
        // Fields from bit 0 up; padded to whole bytes
        out_data_r <= {6'd0, job_r.flip_y, job_r.flip_x,
                       (job_r.type_code >= 4'd9), img_class, job_r.entry_bytes,
                       job_r.first_entry, job_r.entry_count, job_r.pixel_bytes,
                       job_r.height, job_r.width, status};
      end
    end
  end

endmodule

// File: rtl/targa_header_validator.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in_      input      in_tvalid / in_tready  tdata: data_byte; tuser: first_byte
// out_     output     out_tvalid/out_tready  tdata: one result per header, status first
// cfg_     input      cfg_valid / cfg_ready  file_length, always ready
//
// One byte per cycle is taken while the two-entry job queue has room.
// Jobs pass S_MUL, S_PIX, S_SUM (multiplier chain) to S_CHK; error jobs jump to S_CHK.
// Synchronous active-low reset clears parser position, queue and checker state.
// A stalled result output holds the checker; the parser keeps taking bytes until
// the queue fills.

module targa_header_validator
  import tga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tuser,   // [0] first_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  // [3:0] status, [19:4] width in pixels, [35:20] height in pixels, [41:36] pixel_bytes,
  // [57:42] map_length, [73:58] map_first_index, [76:74] map_entry_bytes,
  // [78:77] image_class, [79] run_length_coded, [80] horizontal flip,
  // [81] vertical flip, [87:82] zero
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  logic [31:0] flen_r;
  logic        push, full, pop, empty;
  tga_job_t    push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      flen_r <= cfg_data;
    end
  end

  tga_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_data  (in_tdata),
    .byte_first (in_tuser),
    .byte_ready (in_tready),
    .job_push   (push),
    .job        (push_job),
    .job_full   (full)
  );

  tga_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_job  (pop_job)
  );

  tga_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .file_length (flen_r),
    .job_empty   (empty),
    .job_in      (pop_job),
    .job_pop     (pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_data    (out_tdata)
  );

endmodule
